// ===== hw/rtl/mr3x_pkg.sv =====
package mr3x_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned RIDX = 5;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_DIV   = 6'h1a;
    localparam logic [5:0] FN_DIVU  = 6'h1b;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_SLT   = 6'h2a;
    localparam logic [5:0] FN_SLTU  = 6'h2b;

    localparam logic [5:0] RI_BLTZ  = 6'h00;
    localparam logic [5:0] RI_BGEZ  = 6'h01;

    localparam logic [RIDX-1:0] LINK_REG = 5'd31;
    localparam logic [XLEN-1:0] SEG_MASK = 32'hf000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DFIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic start_div;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_div;
        logic div_last;
    } t_sts;

endpackage

// ===== hw/rtl/mips_r3000_execute_stage.sv =====
// MIPS-I integer execute stage: one decoded instruction per input transfer, one result
// transfer per instruction. Operands are read from a 32-entry register file at the
// accepting edge and executed in the execute state; DIV and DIVU then pass through a
// radix-2 restoring divider, one quotient bit per cycle. A finished result waits in the
// output register while the next instruction is accepted.
module mips_r3000_execute_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [5:0]  i_opcode,
    input  logic [5:0]  i_func_code,
    input  logic [4:0]  i_src_index,
    input  logic [4:0]  i_tgt_index,
    input  logic [4:0]  i_dst_index,
    input  logic [4:0]  i_shift_amount,
    input  logic [25:0] i_immediate,
    input  logic [31:0] i_fetch_pc,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reg_write,
    output logic [4:0]  o_write_index,
    output logic [31:0] o_write_value,
    output logic [31:0] o_next_pc,
    output logic [31:0] o_mem_address,
    output logic        o_illegal
);

    mr3x_pkg::t_cmd w_cmd;
    mr3x_pkg::t_sts w_sts;

    mr3x_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mr3x_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (i_opcode),
        .i_func_code    (i_func_code),
        .i_src_index    (i_src_index),
        .i_tgt_index    (i_tgt_index),
        .i_dst_index    (i_dst_index),
        .i_shift_amount (i_shift_amount),
        .i_immediate    (i_immediate),
        .i_fetch_pc     (i_fetch_pc),
        .o_reg_write    (o_reg_write),
        .o_write_index  (o_write_index),
        .o_write_value  (o_write_value),
        .o_next_pc      (o_next_pc),
        .o_mem_address  (o_mem_address),
        .o_illegal      (o_illegal)
    );

endmodule

// ===== hw/rtl/mr3x_ctrl.sv =====
module mr3x_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  mr3x_pkg::t_sts i_sts,
    output mr3x_pkg::t_cmd o_cmd
);

    mr3x_pkg::t_state r_state, n_state;
    logic             r_ovld, n_ovld;
    logic             w_out_free;

    assign w_out_free  = !r_ovld || !i_out_stall;
    assign o_out_valid = r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mr3x_pkg::S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            mr3x_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = mr3x_pkg::S_EXEC;
                end
            end
            mr3x_pkg::S_EXEC: begin
                if (i_sts.is_div) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = mr3x_pkg::S_DIV;
                end else if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = mr3x_pkg::S_IDLE;
                end
            end
            mr3x_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = mr3x_pkg::S_DFIN;
                end
            end
            mr3x_pkg::S_DFIN: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = mr3x_pkg::S_IDLE;
                end
            end
            default: n_state = mr3x_pkg::S_IDLE;
        endcase
        if (o_cmd.finish) begin
            n_ovld = 1'b1;
        end else if (!i_out_stall) begin
            n_ovld = 1'b0;
        end else begin
            n_ovld = r_ovld;
        end
    end

    a_no_finish_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mr3x_pkg::S_DIV) |-> !o_cmd.finish)
        else $error("finish issued during divide");
    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_ovld)
        else $error("result lost after finish");
    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> w_out_free)
        else $error("result overwritten");
    a_capture_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> (r_state == mr3x_pkg::S_IDLE))
        else $error("capture outside idle");

endmodule

// ===== hw/rtl/mr3x_dp.sv =====
module mr3x_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mr3x_pkg::t_cmd i_cmd,
    output mr3x_pkg::t_sts o_sts,
    input  logic [5:0]     i_opcode,
    input  logic [5:0]     i_func_code,
    input  logic [4:0]     i_src_index,
    input  logic [4:0]     i_tgt_index,
    input  logic [4:0]     i_dst_index,
    input  logic [4:0]     i_shift_amount,
    input  logic [25:0]    i_immediate,
    input  logic [31:0]    i_fetch_pc,
    output logic           o_reg_write,
    output logic [4:0]     o_write_index,
    output logic [31:0]    o_write_value,
    output logic [31:0]    o_next_pc,
    output logic [31:0]    o_mem_address,
    output logic           o_illegal
);

    logic [31:0] mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_s_raw, r_t_raw;
    logic        r_s_ok, r_t_ok;
    logic [5:0]  r_op, r_fn;
    logic [4:0]  r_rt, r_rd, r_sa;
    logic [25:0] r_imm;
    logic [31:0] r_pc;
    logic [31:0] r_hi, r_lo;
    logic [31:0] r_dvd, r_rem, r_dvs;
    logic        r_neg_q, r_neg_r;
    logic [4:0]  r_cnt;

    logic [31:0] w_s, w_t, w_simm, w_imm16, w_pcm4, w_bt, w_jt;
    logic        w_wr, w_ill, w_div, w_sgn, w_we;
    logic [4:0]  w_widx;
    logic [31:0] w_wval, w_npc, w_addr;
    logic [32:0] w_sh, w_diff;

    assign w_s     = r_s_ok ? r_s_raw : '0;
    assign w_t     = r_t_ok ? r_t_raw : '0;
    assign w_imm16 = {16'h0000, r_imm[15:0]};
    assign w_simm  = {{16{r_imm[15]}}, r_imm[15:0]};
    assign w_pcm4  = r_pc - 32'd4;
    assign w_bt    = w_pcm4 + {w_simm[29:0], 2'b00};
    assign w_jt    = (w_pcm4 & mr3x_pkg::SEG_MASK) | {4'h0, r_imm, 2'b00};

    always_comb begin
        w_wr   = 1'b0;
        w_widx = '0;
        w_wval = '0;
        w_npc  = r_pc;
        w_addr = '0;
        w_ill  = 1'b0;
        w_div  = 1'b0;
        w_sgn  = 1'b0;
        unique case (r_op) inside
            mr3x_pkg::OP_SPECIAL: begin
                w_wr   = 1'b1;
                w_widx = r_rd;
                unique case (r_fn) inside
                    mr3x_pkg::FN_SLL:  w_wval = w_t << r_sa;
                    mr3x_pkg::FN_SRL:  w_wval = w_t >> r_sa;
                    mr3x_pkg::FN_SRA:  w_wval = 32'($signed(w_t) >>> r_sa);
                    mr3x_pkg::FN_JR: begin
                        w_wr  = 1'b0;
                        w_npc = w_s;
                    end
                    mr3x_pkg::FN_JALR: begin
                        w_wval = r_pc;
                        w_npc  = w_s;
                    end
                    mr3x_pkg::FN_MFHI: w_wval = r_hi;
                    mr3x_pkg::FN_MFLO: w_wval = r_lo;
                    mr3x_pkg::FN_DIV: begin
                        w_wr  = 1'b0;
                        w_div = 1'b1;
                        w_sgn = 1'b1;
                    end
                    mr3x_pkg::FN_DIVU: begin
                        w_wr  = 1'b0;
                        w_div = 1'b1;
                    end
                    mr3x_pkg::FN_ADD, mr3x_pkg::FN_ADDU: w_wval = w_s + w_t;
                    mr3x_pkg::FN_SUB, mr3x_pkg::FN_SUBU: w_wval = w_s - w_t;
                    mr3x_pkg::FN_AND:  w_wval = w_s & w_t;
                    mr3x_pkg::FN_OR:   w_wval = w_s | w_t;
                    mr3x_pkg::FN_XOR:  w_wval = w_s ^ w_t;
                    mr3x_pkg::FN_SLT:  w_wval = {31'd0, $signed(w_s) < $signed(w_t)};
                    mr3x_pkg::FN_SLTU: w_wval = {31'd0, w_s < w_t};
                    default: begin
                        w_wr  = 1'b0;
                        w_ill = 1'b1;
                    end
                endcase
            end
            mr3x_pkg::OP_REGIMM: begin
                if (r_fn == mr3x_pkg::RI_BLTZ) begin
                    if (w_s[31]) w_npc = w_bt;
                end else if (r_fn == mr3x_pkg::RI_BGEZ) begin
                    if (!w_s[31]) w_npc = w_bt;
                end else begin
                    w_ill = 1'b1;
                end
            end
            mr3x_pkg::OP_J: w_npc = w_jt;
            mr3x_pkg::OP_JAL: begin
                w_wr   = 1'b1;
                w_widx = mr3x_pkg::LINK_REG;
                w_wval = r_pc;
                w_npc  = w_jt;
            end
            mr3x_pkg::OP_BEQ:  if (w_s == w_t) w_npc = w_bt;
            mr3x_pkg::OP_BNE:  if (w_s != w_t) w_npc = w_bt;
            mr3x_pkg::OP_BLEZ: if (w_s[31] || w_s == '0) w_npc = w_bt;
            mr3x_pkg::OP_BGTZ: if (!w_s[31] && w_s != '0) w_npc = w_bt;
            mr3x_pkg::OP_ADDI, mr3x_pkg::OP_ADDIU: begin
                w_wr = 1'b1; w_widx = r_rt; w_wval = w_s + w_simm;
            end
            mr3x_pkg::OP_SLTI: begin
                w_wr = 1'b1; w_widx = r_rt;
                w_wval = {31'd0, $signed(w_s) < $signed(w_simm)};
            end
            mr3x_pkg::OP_SLTIU: begin
                w_wr = 1'b1; w_widx = r_rt; w_wval = {31'd0, w_s < w_simm};
            end
            mr3x_pkg::OP_ANDI: begin
                w_wr = 1'b1; w_widx = r_rt; w_wval = w_s & w_imm16;
            end
            mr3x_pkg::OP_ORI: begin
                w_wr = 1'b1; w_widx = r_rt; w_wval = w_s | w_imm16;
            end
            mr3x_pkg::OP_XORI: begin
                w_wr = 1'b1; w_widx = r_rt; w_wval = w_s ^ w_imm16;
            end
            mr3x_pkg::OP_LUI: begin
                w_wr = 1'b1; w_widx = r_rt; w_wval = {r_imm[15:0], 16'h0000};
            end
            mr3x_pkg::OP_LB, mr3x_pkg::OP_LW, mr3x_pkg::OP_LBU,
            mr3x_pkg::OP_SB, mr3x_pkg::OP_SH, mr3x_pkg::OP_SW: w_addr = w_s + w_simm;
            default: w_ill = 1'b1;
        endcase
        if (w_wr && w_widx == '0) begin
            w_wr = 1'b0;
        end
        if (!w_wr) begin
            w_widx = '0;
            w_wval = '0;
        end
    end

    assign w_we            = i_cmd.finish && w_wr;
    assign o_sts.is_div    = w_div;
    assign o_sts.div_last  = (r_cnt == '1);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_widx] <= w_wval;
        end
        if (i_cmd.capture) begin
            r_s_raw <= mem[i_src_index];
            r_t_raw <= mem[i_tgt_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[w_widx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_s_ok <= r_vld[i_src_index] && (i_src_index != '0);
            r_t_ok <= r_vld[i_tgt_index] && (i_tgt_index != '0);
            r_op   <= i_opcode;
            r_fn   <= i_func_code;
            r_rt   <= i_tgt_index;
            r_rd   <= i_dst_index;
            r_sa   <= i_shift_amount;
            r_imm  <= i_immediate;
            r_pc   <= i_fetch_pc;
        end
    end

    assign w_sh   = {r_rem, r_dvd[31]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_dvd   <= (w_sgn && w_s[31]) ? (32'd0 - w_s) : w_s;
            r_dvs   <= (w_sgn && w_t[31]) ? (32'd0 - w_t) : w_t;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_neg_q <= w_sgn && (w_s[31] != w_t[31]);
            r_neg_r <= w_sgn && w_s[31];
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
                r_dvd <= {r_dvd[30:0], 1'b1};
            end else begin
                r_rem <= w_sh[31:0];
                r_dvd <= {r_dvd[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (i_cmd.finish && w_div) begin
            r_lo <= r_neg_q ? (32'd0 - r_dvd) : r_dvd;
            r_hi <= r_neg_r ? (32'd0 - r_rem) : r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_reg_write   <= w_wr;
            o_write_index <= w_widx;
            o_write_value <= w_wval;
            o_next_pc     <= w_npc;
            o_mem_address <= w_addr;
            o_illegal     <= w_ill;
        end
    end

endmodule

// ===== tb/sv/tb_mips_r3000_execute_stage.sv =====
`timescale 1ns / 100ps

module tb_mips_r3000_execute_stage;

    typedef struct packed {
        logic [5:0]  opcode;
        logic [5:0]  func_code;
        logic [4:0]  src_index;
        logic [4:0]  tgt_index;
        logic [4:0]  dst_index;
        logic [4:0]  shift_amount;
        logic [25:0] immediate;
        logic [31:0] fetch_pc;
    } t_instr;

    typedef struct packed {
        logic        reg_write;
        logic [4:0]  write_index;
        logic [31:0] write_value;
        logic [31:0] next_pc;
        logic [31:0] mem_address;
        logic        illegal;
    } t_outcome;

    class exec_scoreboard;
        logic [31:0] gpr [32];
        logic [31:0] hi;
        logic [31:0] lo;
        t_outcome    pending [$];
        int          errors;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            hi = '0;
            lo = '0;
            errors = 0;
        endfunction

        function logic [31:0] rd(logic [4:0] n);
            return (n == 0) ? 32'd0 : gpr[n];
        endfunction

        function void signed_div(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma, mb, q, r;
            if (b == 0) begin
                lo = a[31] ? 32'd1 : 32'hffff_ffff;
                hi = a;
                return;
            end
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r = ma % mb;
            lo = (a[31] != b[31]) ? -q : q;
            hi = a[31] ? -r : r;
        endfunction

        function void note_instr(t_instr x);
            logic [31:0] s, t, simm, btgt, jtgt;
            t_outcome o;
            s = rd(x.src_index);
            t = rd(x.tgt_index);
            simm = {{16{x.immediate[15]}}, x.immediate[15:0]};
            btgt = (x.fetch_pc - 32'd4) + (simm << 2);
            jtgt = ((x.fetch_pc - 32'd4) & mr3x_pkg::SEG_MASK) | {4'd0, x.immediate, 2'b00};
            o = '0;
            o.next_pc = x.fetch_pc;
            case (x.opcode)
                mr3x_pkg::OP_SPECIAL: begin
                    o.reg_write = 1'b1;
                    o.write_index = x.dst_index;
                    case (x.func_code)
                        mr3x_pkg::FN_SLL:  o.write_value = t << x.shift_amount;
                        mr3x_pkg::FN_SRL:  o.write_value = t >> x.shift_amount;
                        mr3x_pkg::FN_SRA:  o.write_value = $signed(t) >>> x.shift_amount;
                        mr3x_pkg::FN_JR: begin
                            o.reg_write = 1'b0;
                            o.next_pc = s;
                        end
                        mr3x_pkg::FN_JALR: begin
                            o.write_value = x.fetch_pc;
                            o.next_pc = s;
                        end
                        mr3x_pkg::FN_MFHI: o.write_value = hi;
                        mr3x_pkg::FN_MFLO: o.write_value = lo;
                        mr3x_pkg::FN_DIV: begin
                            o.reg_write = 1'b0;
                            signed_div(s, t);
                        end
                        mr3x_pkg::FN_DIVU: begin
                            o.reg_write = 1'b0;
                            if (t == 0) begin
                                lo = 32'hffff_ffff;
                                hi = s;
                            end else begin
                                lo = s / t;
                                hi = s % t;
                            end
                        end
                        mr3x_pkg::FN_ADD, mr3x_pkg::FN_ADDU: o.write_value = s + t;
                        mr3x_pkg::FN_SUB, mr3x_pkg::FN_SUBU: o.write_value = s - t;
                        mr3x_pkg::FN_AND:  o.write_value = s & t;
                        mr3x_pkg::FN_OR:   o.write_value = s | t;
                        mr3x_pkg::FN_XOR:  o.write_value = s ^ t;
                        mr3x_pkg::FN_SLT:
                            o.write_value = ($signed(s) < $signed(t)) ? 32'd1 : 32'd0;
                        mr3x_pkg::FN_SLTU: o.write_value = (s < t) ? 32'd1 : 32'd0;
                        default: begin
                            o.reg_write = 1'b0;
                            o.illegal = 1'b1;
                        end
                    endcase
                end
                mr3x_pkg::OP_REGIMM: begin
                    if (x.func_code == mr3x_pkg::RI_BLTZ) begin
                        if (s[31]) o.next_pc = btgt;
                    end else if (x.func_code == mr3x_pkg::RI_BGEZ) begin
                        if (!s[31]) o.next_pc = btgt;
                    end else begin
                        o.illegal = 1'b1;
                    end
                end
                mr3x_pkg::OP_J: o.next_pc = jtgt;
                mr3x_pkg::OP_JAL: begin
                    o.reg_write = 1'b1;
                    o.write_index = mr3x_pkg::LINK_REG;
                    o.write_value = x.fetch_pc;
                    o.next_pc = jtgt;
                end
                mr3x_pkg::OP_BEQ:  if (s == t) o.next_pc = btgt;
                mr3x_pkg::OP_BNE:  if (s != t) o.next_pc = btgt;
                mr3x_pkg::OP_BLEZ: if (s[31] || s == 0) o.next_pc = btgt;
                mr3x_pkg::OP_BGTZ: if (!s[31] && s != 0) o.next_pc = btgt;
                mr3x_pkg::OP_ADDI, mr3x_pkg::OP_ADDIU, mr3x_pkg::OP_SLTI,
                mr3x_pkg::OP_SLTIU, mr3x_pkg::OP_ANDI, mr3x_pkg::OP_ORI,
                mr3x_pkg::OP_XORI, mr3x_pkg::OP_LUI: begin
                    o.reg_write = 1'b1;
                    o.write_index = x.tgt_index;
                    case (x.opcode)
                        mr3x_pkg::OP_SLTI:
                            o.write_value = ($signed(s) < $signed(simm)) ? 32'd1 : 32'd0;
                        mr3x_pkg::OP_SLTIU: o.write_value = (s < simm) ? 32'd1 : 32'd0;
                        mr3x_pkg::OP_ANDI:  o.write_value = s & {16'd0, x.immediate[15:0]};
                        mr3x_pkg::OP_ORI:   o.write_value = s | {16'd0, x.immediate[15:0]};
                        mr3x_pkg::OP_XORI:  o.write_value = s ^ {16'd0, x.immediate[15:0]};
                        mr3x_pkg::OP_LUI:   o.write_value = {x.immediate[15:0], 16'd0};
                        default:            o.write_value = s + simm;
                    endcase
                end
                mr3x_pkg::OP_LB, mr3x_pkg::OP_LW, mr3x_pkg::OP_LBU,
                mr3x_pkg::OP_SB, mr3x_pkg::OP_SH, mr3x_pkg::OP_SW: o.mem_address = s + simm;
                default: o.illegal = 1'b1;
            endcase
            if (o.reg_write && o.write_index == 0) o.reg_write = 1'b0;
            if (o.reg_write) begin
                gpr[o.write_index] = o.write_value;
            end else begin
                o.write_index = '0;
                o.write_value = '0;
            end
            pending.push_back(o);
        endfunction

        function void check_outcome(t_outcome a);
            t_outcome e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.reg_write !== e.reg_write) begin
                $display("%0t: reg_write exp %h got %h", $time, e.reg_write, a.reg_write);
                errors++;
            end
            if (a.write_index !== e.write_index) begin
                $display("%0t: write_index exp %h got %h", $time, e.write_index, a.write_index);
                errors++;
            end
            if (a.write_value !== e.write_value) begin
                $display("%0t: write_value exp %h got %h", $time, e.write_value, a.write_value);
                errors++;
            end
            if (a.next_pc !== e.next_pc) begin
                $display("%0t: next_pc exp %h got %h", $time, e.next_pc, a.next_pc);
                errors++;
            end
            if (a.mem_address !== e.mem_address) begin
                $display("%0t: mem_address exp %h got %h", $time, e.mem_address, a.mem_address);
                errors++;
            end
            if (a.illegal !== e.illegal) begin
                $display("%0t: illegal exp %h got %h", $time, e.illegal, a.illegal);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_instr      instr = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_outcome    outcome;
    logic        sender_done = 1'b0;
    logic        hold_off = 1'b0;
    int          idle_cycles = 0;
    exec_scoreboard board = new();

    always #5 i_clk = ~i_clk;

    mips_r3000_execute_stage DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (instr.opcode),
        .i_func_code    (instr.func_code),
        .i_src_index    (instr.src_index),
        .i_tgt_index    (instr.tgt_index),
        .i_dst_index    (instr.dst_index),
        .i_shift_amount (instr.shift_amount),
        .i_immediate    (instr.immediate),
        .i_fetch_pc     (instr.fetch_pc),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_reg_write    (outcome.reg_write),
        .o_write_index  (outcome.write_index),
        .o_write_value  (outcome.write_value),
        .o_next_pc      (outcome.next_pc),
        .o_mem_address  (outcome.mem_address),
        .o_illegal      (outcome.illegal)
    );

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_instr random_instr();
        t_instr x;
        logic [5:0] ops [22];
        logic [5:0] fns [18];
        ops = '{mr3x_pkg::OP_SPECIAL, mr3x_pkg::OP_REGIMM, mr3x_pkg::OP_J, mr3x_pkg::OP_JAL,
                mr3x_pkg::OP_BEQ, mr3x_pkg::OP_BNE, mr3x_pkg::OP_BLEZ, mr3x_pkg::OP_BGTZ,
                mr3x_pkg::OP_ADDI, mr3x_pkg::OP_ADDIU, mr3x_pkg::OP_SLTI, mr3x_pkg::OP_SLTIU,
                mr3x_pkg::OP_ANDI, mr3x_pkg::OP_ORI, mr3x_pkg::OP_XORI, mr3x_pkg::OP_LUI,
                mr3x_pkg::OP_LB, mr3x_pkg::OP_LW, mr3x_pkg::OP_LBU, mr3x_pkg::OP_SB,
                mr3x_pkg::OP_SH, mr3x_pkg::OP_SW};
        fns = '{mr3x_pkg::FN_SLL, mr3x_pkg::FN_SRL, mr3x_pkg::FN_SRA, mr3x_pkg::FN_JR,
                mr3x_pkg::FN_JALR, mr3x_pkg::FN_MFHI, mr3x_pkg::FN_MFLO, mr3x_pkg::FN_DIV,
                mr3x_pkg::FN_DIVU, mr3x_pkg::FN_ADD, mr3x_pkg::FN_ADDU, mr3x_pkg::FN_SUB,
                mr3x_pkg::FN_SUBU, mr3x_pkg::FN_AND, mr3x_pkg::FN_OR, mr3x_pkg::FN_XOR,
                mr3x_pkg::FN_SLT, mr3x_pkg::FN_SLTU};
        x = '0;
        x.opcode = ($urandom_range(0, 15) == 0) ? 6'($urandom) : ops[$urandom_range(0, 21)];
        if ($urandom_range(0, 2) == 0) x.opcode = mr3x_pkg::OP_SPECIAL;
        if (x.opcode == mr3x_pkg::OP_SPECIAL)
            x.func_code = ($urandom_range(0, 15) == 0) ? 6'($urandom)
                                                       : fns[$urandom_range(0, 17)];
        else if (x.opcode == mr3x_pkg::OP_REGIMM)
            x.func_code = ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(0, 1));
        else
            x.func_code = 6'($urandom);
        if (x.opcode == mr3x_pkg::OP_SPECIAL
            && (x.func_code == mr3x_pkg::FN_DIV || x.func_code == mr3x_pkg::FN_DIVU)
            && $urandom_range(0, 1) == 0)
            x.func_code = mr3x_pkg::FN_ADDU;
        x.src_index = 5'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 7));
        x.tgt_index = 5'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 7));
        x.dst_index = 5'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 7));
        x.shift_amount = 5'($urandom);
        x.immediate = 26'($urandom);
        x.fetch_pc = $urandom;
        return x;
    endfunction

    task automatic send_instr(t_instr x);
        i_in_valid <= 1'b1;
        instr <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_instr(x);
    endtask

    task automatic send_op(logic [5:0] op, logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                           logic [4:0] rd, logic [4:0] sa, logic [25:0] imm, logic [31:0] pc);
        send_instr('{op, fn, rs, rt, rd, sa, imm, pc});
    endtask

    task automatic load_reg(logic [4:0] r, logic [31:0] v);
        send_op(mr3x_pkg::OP_LUI, 6'd0, 5'd0, r, 5'd0, 5'd0, {10'd0, v[31:16]}, 32'h100);
        send_op(mr3x_pkg::OP_ORI, 6'd0, r, r, 5'd0, 5'd0, {10'd0, v[15:0]}, 32'h104);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 6);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin : sender
        int burst;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_reg(5'd1, 32'h8000_0000);
        load_reg(5'd2, 32'hffff_ffff);
        load_reg(5'd3, 32'h7fff_ffff);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0, 26'd0, 32'h200);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_MFLO, 5'd0, 5'd0, 5'd4, 5'd0, 26'd0,
                32'h204);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_MFHI, 5'd0, 5'd0, 5'd5, 5'd0, 26'd0,
                32'h208);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0, 26'd0, 32'h20c);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_MFLO, 5'd0, 5'd0, 5'd4, 5'd0, 26'd0,
                32'h210);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_DIV, 5'd3, 5'd0, 5'd0, 5'd0, 26'd0, 32'h214);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_MFLO, 5'd0, 5'd0, 5'd4, 5'd0, 26'd0,
                32'h218);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_DIVU, 5'd2, 5'd0, 5'd0, 5'd0, 26'd0,
                32'h21c);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_MFHI, 5'd0, 5'd0, 5'd6, 5'd0, 26'd0,
                32'h220);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_JALR, 5'd3, 5'd0, 5'd3, 5'd0, 26'd0,
                32'h224);
        send_op(mr3x_pkg::OP_JAL, 6'd0, 5'd0, 5'd0, 5'd0, 5'd0, 26'h3ff_ffff, 32'h0000_0000);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_ADD, 5'd3, 5'd3, 5'd0, 5'd0, 26'd0,
                32'hffff_ffff);
        send_op(mr3x_pkg::OP_SPECIAL, mr3x_pkg::FN_SRA, 5'd0, 5'd1, 5'd7, 5'd31, 26'd0,
                32'h230);
        send_op(mr3x_pkg::OP_ADDI, 6'd0, 5'd3, 5'd8, 5'd0, 5'd0, 26'h000_8000, 32'h234);
        send_op(mr3x_pkg::OP_BEQ, 6'd0, 5'd0, 5'd0, 5'd0, 5'd0, 26'h000_8000, 32'h0000_0004);
        send_op(mr3x_pkg::OP_BLEZ, 6'd0, 5'd0, 5'd0, 5'd0, 5'd0, 26'h000_7fff, 32'hffff_fffc);
        send_op(mr3x_pkg::OP_SW, 6'h3f, 5'd2, 5'd0, 5'd0, 5'd0, 26'h3ff_ffff, 32'h240);
        send_op(6'h3f, 6'h3f, 5'd31, 5'd31, 5'd31, 5'd31, 26'h3ff_ffff, 32'h244);
        send_op(mr3x_pkg::OP_REGIMM, 6'h3f, 5'd1, 5'd0, 5'd0, 5'd0, 26'd4, 32'h248);
        for (int k = 0; k < 950; k++) begin
            if (k % 40 == 0) begin
                for (int r = 1; r < 8; r++) load_reg(5'(r), pick_value());
                k += 14;
            end
            burst = $urandom_range(0, 3);
            if (burst == 0 && k > 100) idle_gap();
            send_instr(random_instr());
        end
        i_in_valid <= 1'b0;
        sender_done <= 1'b1;
    end

    initial begin : receiver
        int mode;
        wait (i_rst_n);
        repeat (60) @(posedge i_clk);
        hold_off <= 1'b1;
        i_out_stall <= 1'b1;
        repeat (80) @(posedge i_clk);
        hold_off <= 1'b0;
        forever begin
            mode = $urandom_range(0, 9);
            i_out_stall <= (mode < 3);
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            if ($urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b0;
                repeat (40) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_outcome(outcome);
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : finisher
        wait (sender_done);
        while (board.pending.size() != 0 && idle_cycles < WATCHDOG) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mr3x_pkg.sv
hw/rtl/mr3x_ctrl.sv
hw/rtl/mr3x_dp.sv
hw/rtl/mips_r3000_execute_stage.sv
tb/sv/tb_mips_r3000_execute_stage.sv
